[design/lcsp_pkg.sv]
// Shared types, constants and helper functions of the display command-stream parser.
`default_nettype none
package lcsp_pkg;

    localparam logic [7:0] CHAR_FIRST  = 8'h21;
    localparam logic [7:0] CHAR_END    = 8'h7E;
    localparam logic [7:0] CMD_CLEAR   = 8'h0D;
    localparam logic [7:0] CMD_CHAR    = 8'h01;
    localparam logic [7:0] CMD_GOTO    = 8'h02;
    localparam logic [7:0] CMD_STR     = 8'h03;
    localparam logic [7:0] CMD_PACKED  = 8'h07;
    localparam logic [7:0] DIGIT_0     = 8'h30;
    localparam logic [7:0] DIGIT_9     = 8'h39;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_F     = 8'h46;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_F     = 8'h66;
    localparam logic [7:0] SIGN_PLUS   = 8'h2B;
    localparam logic [7:0] SIGN_MINUS  = 8'h2D;

    localparam int FLAG_CHAR   = 0;
    localparam int FLAG_GOTO   = 1;
    localparam int FLAG_STRING = 2;
    localparam int FLAG_PACKED = 4;

    localparam int MAX_RESULTS = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_STRING = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [7:0] column;
        logic [7:0] row;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {
        CK_RESULT = 2'd0,
        CK_WRITE  = 2'd1,
        CK_STRING = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        t_result    res;
        logic       wr_en;
        logic [7:0] wr_slot;
        logic [7:0] wr_data;
        logic       mark_en;
        logic [7:0] mark_slot;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE  = 3'd0,
        B_MARK  = 3'd1,
        B_START = 3'd2,
        B_FIRST = 3'd3,
        B_LOOK  = 3'd4,
        B_TAIL  = 3'd5
    } t_back_state;

    // Bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            d = {1'b1, c[3:0]};
        end else if ((c >= UPPER_A && c <= UPPER_F) || (c >= LOWER_A && c <= LOWER_F)) begin
            d = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return d;
    endfunction

    // Base-16 read of two characters with optional sign, low 8 bits of the result.
    function automatic logic [7:0] parse_two(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] da;
        logic [4:0] db;
        logic [7:0] v;
        da = hex_digit(a);
        db = hex_digit(b);
        if (a == SIGN_PLUS || a == SIGN_MINUS) begin
            v = db[4] ? {4'h0, db[3:0]} : 8'd0;
            if (a == SIGN_MINUS) begin
                v = 8'd0 - v;
            end
        end else if (!da[4]) begin
            v = 8'd0;
        end else if (!db[4]) begin
            v = {4'h0, da[3:0]};
        end else begin
            v = {da[3:0], db[3:0]};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[design/lcsp_if.sv]
// Handshake interfaces for the received-byte and display-action channels.
`default_nettype none
interface lcsp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcsp_act_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;
    logic       last;
    modport source (output valid, output action, output char_code, output column,
                    output row, output last, input ready);
    modport sink (input valid, input action, input char_code, input column,
                  input row, input last, output ready);
endinterface
`default_nettype wire

[design/lcsp_front.sv]
// Front end: accepts received bytes, tracks task state and issues commands to the queue.
`default_nettype none
module lcsp_front #(
    parameter int STRING_DEPTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lcsp_rx_if.sink            i_rx,
    input  wire logic          i_space,
    output lcsp_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid
);

    localparam logic [8:0] DEPTH9 = 9'(STRING_DEPTH);

    logic [4:0] r_flags, n_flags;
    logic [7:0] r_ci, n_ci;
    logic [7:0] r_gi, n_gi;
    logic [7:0] r_si, n_si;
    logic [7:0] r_slen, n_slen;
    logic [7:0] r_hp [2];
    logic [7:0] n_hp [2];
    logic [7:0] r_gt [4];
    logic [7:0] n_gt [4];

    logic       w_accept;
    logic [7:0] w_b;
    logic [7:0] w_v;
    logic [7:0] w_c;
    logic [7:0] w_r;
    logic [7:0] w_slot;
    logic [7:0] w_mark;

    assign i_rx.ready = i_space;
    assign w_accept   = i_rx.valid && i_space;
    assign w_b        = i_rx.rx_byte;

    always_comb begin
        n_flags     = r_flags;
        n_ci        = r_ci;
        n_gi        = r_gi;
        n_si        = r_si;
        n_slen      = r_slen;
        n_hp        = r_hp;
        n_gt        = r_gt;
        o_cmd       = '0;
        o_cmd_valid = 1'b0;
        w_v         = 8'd0;
        w_c         = 8'd0;
        w_r         = 8'd0;
        w_slot      = 8'd0;
        w_mark      = 8'd0;
        if (w_accept) begin
            if (w_b < lcsp_pkg::CHAR_FIRST) begin
                case (w_b)
                    lcsp_pkg::CMD_CLEAR: begin
                        n_flags = 5'd0;
                        n_ci    = 8'd0;
                        n_gi    = 8'd0;
                        n_si    = 8'd0;
                    end
                    lcsp_pkg::CMD_CHAR:   n_flags[lcsp_pkg::FLAG_CHAR] = 1'b1;
                    lcsp_pkg::CMD_GOTO:   n_flags[lcsp_pkg::FLAG_GOTO] = 1'b1;
                    lcsp_pkg::CMD_STR:    n_flags[lcsp_pkg::FLAG_STRING] = 1'b1;
                    lcsp_pkg::CMD_PACKED: n_flags[lcsp_pkg::FLAG_PACKED] = 1'b1;
                    default: ;
                endcase
            end else if (w_b < lcsp_pkg::CHAR_END) begin
                if (r_flags[lcsp_pkg::FLAG_PACKED] || r_flags[lcsp_pkg::FLAG_GOTO]) begin
                    if (r_gi < 8'd4) begin
                        n_gt[r_gi[1:0]] = w_b;
                    end
                    n_gi = r_gi + 8'd1;
                    if (r_flags[lcsp_pkg::FLAG_PACKED]) begin
                        if (n_gi == 8'd2) begin
                            n_flags[lcsp_pkg::FLAG_PACKED] = 1'b0;
                            w_v = lcsp_pkg::parse_two(n_gt[0], n_gt[1]) - lcsp_pkg::DIGIT_0;
                            o_cmd_valid          = 1'b1;
                            o_cmd.kind           = lcsp_pkg::CK_RESULT;
                            o_cmd.res.action     = lcsp_pkg::ACT_MOVE;
                            o_cmd.res.column     = {3'd0, w_v[7:3]};
                            o_cmd.res.row        = {5'd0, w_v[2:0]};
                            o_cmd.res.last       = 1'b1;
                        end
                    end else if (n_gi == 8'd4) begin
                        n_flags[lcsp_pkg::FLAG_GOTO] = 1'b0;
                        w_c = lcsp_pkg::parse_two(n_gt[0], n_gt[1]) - lcsp_pkg::DIGIT_0;
                        w_r = lcsp_pkg::parse_two(n_gt[2], n_gt[3]) - lcsp_pkg::DIGIT_0;
                        o_cmd_valid      = 1'b1;
                        o_cmd.kind       = lcsp_pkg::CK_RESULT;
                        o_cmd.res.action = lcsp_pkg::ACT_MOVE;
                        o_cmd.res.column = w_c;
                        o_cmd.res.row    = w_r;
                        o_cmd.res.last   = 1'b1;
                    end
                end else if (r_flags[lcsp_pkg::FLAG_CHAR]) begin
                    if (r_ci < 8'd2) begin
                        n_hp[r_ci[0]] = w_b;
                    end
                    n_ci = r_ci + 8'd1;
                    if (n_ci == 8'd2) begin
                        n_flags[lcsp_pkg::FLAG_CHAR] = 1'b0;
                        o_cmd_valid         = 1'b1;
                        o_cmd.kind          = lcsp_pkg::CK_RESULT;
                        o_cmd.res.action    = lcsp_pkg::ACT_PUT;
                        o_cmd.res.char_code = lcsp_pkg::parse_two(n_hp[0], n_hp[1]);
                        o_cmd.res.last      = 1'b1;
                    end
                end else if (r_flags[lcsp_pkg::FLAG_STRING]) begin
                    if (r_si == 8'd0) begin
                        n_slen = w_b - lcsp_pkg::DIGIT_0;
                        n_si   = 8'd1;
                    end else begin
                        w_slot        = r_si - 8'd1;
                        o_cmd.wr_en   = ({1'b0, w_slot} < DEPTH9);
                        o_cmd.wr_slot = w_slot;
                        o_cmd.wr_data = w_b;
                        n_si          = r_si + 8'd1;
                    end
                    if ({1'b0, n_si} == ({1'b0, n_slen} + 9'd1)) begin
                        w_mark          = n_si - 8'd1;
                        n_flags[lcsp_pkg::FLAG_STRING] = 1'b0;
                        o_cmd_valid     = 1'b1;
                        o_cmd.kind      = lcsp_pkg::CK_STRING;
                        o_cmd.mark_en   = ({1'b0, w_mark} < DEPTH9);
                        o_cmd.mark_slot = w_mark;
                    end else if (o_cmd.wr_en) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = lcsp_pkg::CK_WRITE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 5'd0;
            r_ci    <= 8'd0;
            r_gi    <= 8'd0;
            r_si    <= 8'd0;
            r_slen  <= 8'd0;
            r_hp    <= '{default: 8'd0};
            r_gt    <= '{default: 8'd0};
        end else begin
            r_flags <= n_flags;
            r_ci    <= n_ci;
            r_gi    <= n_gi;
            r_si    <= n_si;
            r_slen  <= n_slen;
            r_hp    <= n_hp;
            r_gt    <= n_gt;
        end
    end

endmodule
`default_nettype wire

[design/lcsp_queue.sv]
// Small command queue between the front end and the back end.
`default_nettype none
module lcsp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lcsp_pkg::t_cmd  i_cmd,
    output logic                 o_space,
    output logic                 o_valid,
    output lcsp_pkg::t_cmd       o_cmd,
    input  wire logic            i_pop
);

    localparam int AW = $clog2(lcsp_pkg::QUEUE_DEPTH);

    lcsp_pkg::t_cmd r_entry [lcsp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count, n_count;

    assign o_space = (r_count != (AW+1)'(lcsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (AW+1)'(1);
            2'b01:   n_count = r_count - (AW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

[design/lcsp_back.sv]
// Back end: carries out queued commands, owns the string store and drives the action channel.
`default_nettype none
module lcsp_back #(
    parameter int STRING_DEPTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire lcsp_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    lcsp_act_if.source           o_act
);

    localparam int LIMIT = (STRING_DEPTH < lcsp_pkg::MAX_RESULTS) ?
                           STRING_DEPTH : lcsp_pkg::MAX_RESULTS;
    localparam int AW    = $clog2(STRING_DEPTH);
    localparam int IW    = $clog2(LIMIT + 1);

    lcsp_pkg::t_back_state r_state, n_state;

    logic [7:0]        r_mem [STRING_DEPTH];
    logic [7:0]        r_rd_data;
    logic [IW-1:0]     r_idx, n_idx;
    logic [7:0]        r_cur, n_cur;
    logic              r_mark_en, n_mark_en;
    logic [AW-1:0]     r_mark_slot, n_mark_slot;
    lcsp_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              w_free;
    logic              w_load;
    lcsp_pkg::t_result w_res;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [7:0]        w_wr_data;
    logic [AW-1:0]     w_rd_addr;

    assign w_free    = !r_out_valid || o_act.ready;
    assign w_rd_addr = (n_idx < IW'(LIMIT)) ? n_idx[AW-1:0] : '0;

    assign o_act.valid     = r_out_valid;
    assign o_act.action    = r_out.action;
    assign o_act.char_code = r_out.char_code;
    assign o_act.column    = r_out.column;
    assign o_act.row       = r_out.row;
    assign o_act.last      = r_out.last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lcsp_pkg::B_IDLE: begin
                if (i_valid && i_cmd.kind == lcsp_pkg::CK_STRING) begin
                    n_state = lcsp_pkg::B_MARK;
                end
            end
            lcsp_pkg::B_MARK:  n_state = lcsp_pkg::B_START;
            lcsp_pkg::B_START: n_state = lcsp_pkg::B_FIRST;
            lcsp_pkg::B_FIRST: begin
                n_state = (r_rd_data == 8'd0) ? lcsp_pkg::B_IDLE : lcsp_pkg::B_LOOK;
            end
            lcsp_pkg::B_LOOK: begin
                if (w_free) begin
                    if (r_rd_data == 8'd0) begin
                        n_state = lcsp_pkg::B_IDLE;
                    end else if (r_idx == IW'(LIMIT - 1)) begin
                        n_state = lcsp_pkg::B_TAIL;
                    end
                end
            end
            lcsp_pkg::B_TAIL: begin
                if (w_free) begin
                    n_state = lcsp_pkg::B_IDLE;
                end
            end
            default: n_state = lcsp_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_mark_en   = r_mark_en;
        n_mark_slot = r_mark_slot;
        w_load      = 1'b0;
        w_res       = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = i_cmd.wr_slot[AW-1:0];
        w_wr_data   = i_cmd.wr_data;
        case (r_state)
            lcsp_pkg::B_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.kind)
                        lcsp_pkg::CK_RESULT: begin
                            if (w_free) begin
                                o_pop  = 1'b1;
                                w_load = 1'b1;
                                w_res  = i_cmd.res;
                            end
                        end
                        lcsp_pkg::CK_WRITE: begin
                            o_pop   = 1'b1;
                            w_wr_en = i_cmd.wr_en;
                        end
                        lcsp_pkg::CK_STRING: begin
                            o_pop       = 1'b1;
                            w_wr_en     = i_cmd.wr_en;
                            n_mark_en   = i_cmd.mark_en;
                            n_mark_slot = i_cmd.mark_slot[AW-1:0];
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            lcsp_pkg::B_MARK: begin
                w_wr_en   = r_mark_en;
                w_wr_addr = r_mark_slot;
                w_wr_data = 8'd0;
                n_idx     = '0;
            end
            lcsp_pkg::B_START: n_idx = '0;
            lcsp_pkg::B_FIRST: begin
                if (r_rd_data != 8'd0) begin
                    n_cur = r_rd_data;
                    n_idx = IW'(1);
                end
            end
            lcsp_pkg::B_LOOK: begin
                if (w_free) begin
                    w_load          = 1'b1;
                    w_res.action    = lcsp_pkg::ACT_STRING;
                    w_res.char_code = r_cur;
                    w_res.last      = (r_rd_data == 8'd0);
                    if (r_rd_data != 8'd0) begin
                        n_cur = r_rd_data;
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            lcsp_pkg::B_TAIL: begin
                if (w_free) begin
                    w_load          = 1'b1;
                    w_res.action    = lcsp_pkg::ACT_STRING;
                    w_res.char_code = r_cur;
                    w_res.last      = 1'b1;
                end
            end
            default: ;
        endcase
        n_out_valid = r_out_valid && !o_act.ready;
        n_out       = r_out;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcsp_pkg::B_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_mark_en   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_mark_en   <= n_mark_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_mark_slot <= n_mark_slot;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

endmodule
`default_nettype wire

[design/lcd_command_stream_parser.sv]
// Top level of the display command-stream parser.
// i_rx carries received bytes, one per word; o_act carries display actions
// (put character, move cursor, string character) with a last mark on the
// final action that a byte causes. A word moves when valid and ready are high.
// The front end takes one byte per cycle while its command queue has room;
// command bytes and bytes outside the character range produce no action.
// A put-character or cursor action passes through the command queue and the
// back end's output register to o_act. After a string's final byte the back
// end steps through its mark, start and first states, then gives one character
// per cycle while o_act is not stalled; the single string-store read port sets
// that pace. Commands made meanwhile wait in the four-entry queue.
// When o_act is stalled the back end holds its output register and the queue
// fills; i_rx.ready drops only when the queue is full.
// Synchronous reset clears the task flags, indices, queue and output valid flag;
// the string store holds no defined content until characters are written.
`default_nettype none
module lcd_command_stream_parser #(
    parameter int STRING_DEPTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lcsp_rx_if.sink     i_rx,
    lcsp_act_if.source  o_act
);

    lcsp_pkg::t_cmd w_front_cmd;
    logic           w_front_valid;
    logic           w_space;
    lcsp_pkg::t_cmd w_queue_cmd;
    logic           w_queue_valid;
    logic           w_pop;

    lcsp_front #(
        .STRING_DEPTH(STRING_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_space     (w_space),
        .o_cmd       (w_front_cmd),
        .o_cmd_valid (w_front_valid)
    );

    lcsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_cmd   (w_front_cmd),
        .o_space (w_space),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd),
        .i_pop   (w_pop)
    );

    lcsp_back #(
        .STRING_DEPTH(STRING_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_queue_valid),
        .i_cmd   (w_queue_cmd),
        .o_pop   (w_pop),
        .o_act   (o_act)
    );

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the display command-stream parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsp_pkg::*;

    localparam int STRING_DEPTH = 32;
    localparam int EMIT_LIMIT = (STRING_DEPTH < MAX_RESULTS) ? STRING_DEPTH : MAX_RESULTS;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 160;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcsp_rx_if  rx();
    lcsp_act_if act();

    lcd_command_stream_parser #(
        .STRING_DEPTH(STRING_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_act   (act)
    );

    always #6 i_clk = ~i_clk;

    // Parser state as seen from the received byte stream.
    logic [4:0] task_flags = '0;
    logic [7:0] char_idx = '0;
    logic [7:0] goto_idx = '0;
    logic [7:0] str_idx = '0;
    logic [7:0] str_len = '0;
    logic [7:0] pair_text [2] = '{default: '0};
    logic [7:0] cursor_text [4] = '{default: '0};
    logic [7:0] str_mem [STRING_DEPTH] = '{default: '0};

    t_result pending_actions [$];
    t_result seen_action;
    t_result wanted_action;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int words_sent = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    function automatic int hex_val(input logic [7:0] c);
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            return int'(c) - int'(DIGIT_0);
        end
        if (c >= UPPER_A && c <= UPPER_F) begin
            return int'(c) - int'(UPPER_A) + 10;
        end
        if (c >= LOWER_A && c <= LOWER_F) begin
            return int'(c) - int'(LOWER_A) + 10;
        end
        return -1;
    endfunction

    function automatic int read_hex_pair(input logic [7:0] a, input logic [7:0] b);
        int hi;
        int lo;
        hi = hex_val(a);
        lo = hex_val(b);
        if (a == SIGN_PLUS || a == SIGN_MINUS) begin
            if (lo < 0) begin
                lo = 0;
            end
            return (a == SIGN_MINUS) ? -lo : lo;
        end
        if (hi < 0) begin
            return 0;
        end
        if (lo < 0) begin
            return hi;
        end
        return hi * 16 + lo;
    endfunction

    function automatic t_result make_action(input t_action kind, input logic [7:0] ch,
                                            input logic [7:0] col, input logic [7:0] rw,
                                            input logic lst);
        t_result r;
        r.action = kind;
        r.char_code = ch;
        r.column = col;
        r.row = rw;
        r.last = lst;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] v;
        logic [7:0] rw;
        int slot;
        int i;
        t_result tail;
        if (b < CHAR_FIRST) begin
            case (b)
                CMD_CLEAR: begin
                    task_flags = '0;
                    char_idx = '0;
                    goto_idx = '0;
                    str_idx = '0;
                end
                CMD_CHAR: task_flags[FLAG_CHAR] = 1'b1;
                CMD_GOTO: task_flags[FLAG_GOTO] = 1'b1;
                CMD_STR: task_flags[FLAG_STRING] = 1'b1;
                CMD_PACKED: task_flags[FLAG_PACKED] = 1'b1;
                default: begin
                end
            endcase
        end else if (b < CHAR_END) begin
            if (task_flags[FLAG_PACKED] || task_flags[FLAG_GOTO]) begin
                if (goto_idx < 8'd4) begin
                    cursor_text[goto_idx[1:0]] = b;
                end
                goto_idx = goto_idx + 8'd1;
                if (task_flags[FLAG_PACKED]) begin
                    if (goto_idx == 8'd2) begin
                        task_flags[FLAG_PACKED] = 1'b0;
                        v = 8'(read_hex_pair(cursor_text[0], cursor_text[1]) - int'(DIGIT_0));
                        pending_actions.push_back(make_action(ACT_MOVE, 8'd0, {3'd0, v[7:3]},
                                                              {5'd0, v[2:0]}, 1'b1));
                    end
                end else if (goto_idx == 8'd4) begin
                    task_flags[FLAG_GOTO] = 1'b0;
                    v = 8'(read_hex_pair(cursor_text[0], cursor_text[1]) - int'(DIGIT_0));
                    rw = 8'(read_hex_pair(cursor_text[2], cursor_text[3]) - int'(DIGIT_0));
                    pending_actions.push_back(make_action(ACT_MOVE, 8'd0, v, rw, 1'b1));
                end
            end else if (task_flags[FLAG_CHAR]) begin
                if (char_idx < 8'd2) begin
                    pair_text[char_idx[0]] = b;
                end
                char_idx = char_idx + 8'd1;
                if (char_idx == 8'd2) begin
                    task_flags[FLAG_CHAR] = 1'b0;
                    v = 8'(read_hex_pair(pair_text[0], pair_text[1]));
                    pending_actions.push_back(make_action(ACT_PUT, v, 8'd0, 8'd0, 1'b1));
                end
            end else if (task_flags[FLAG_STRING]) begin
                if (str_idx == 8'd0) begin
                    str_len = b - DIGIT_0;
                    str_idx = 8'd1;
                end else begin
                    slot = int'(str_idx) - 1;
                    if (slot < STRING_DEPTH) begin
                        str_mem[slot] = b;
                    end
                    str_idx = str_idx + 8'd1;
                end
                if (int'(str_idx) == int'(str_len) + 1) begin
                    slot = int'(str_idx) - 1;
                    if (slot < STRING_DEPTH) begin
                        str_mem[slot] = 8'h00;
                    end
                    task_flags[FLAG_STRING] = 1'b0;
                    i = 0;
                    while (i < EMIT_LIMIT && str_mem[i] != 8'h00) begin
                        pending_actions.push_back(make_action(ACT_STRING, str_mem[i], 8'd0,
                                                              8'd0, 1'b0));
                        i++;
                    end
                    if (i > 0) begin
                        tail = pending_actions.pop_back();
                        tail.last = 1'b1;
                        pending_actions.push_back(tail);
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && act.valid && act.ready) begin
            seen_action = make_action(t_action'(act.action), act.char_code, act.column,
                                      act.row, act.last);
            if (pending_actions.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual %h", $time,
                         seen_action);
                mismatch_count++;
            end else begin
                wanted_action = pending_actions.pop_front();
                check_field("action", 8'(wanted_action.action), 8'(seen_action.action));
                check_field("char_code", wanted_action.char_code, seen_action.char_code);
                check_field("column", wanted_action.column, seen_action.column);
                check_field("row", wanted_action.row, seen_action.row);
                check_field("last", 8'(wanted_action.last), 8'(seen_action.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rx.valid && rx.ready) || (act.valid && act.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no word accepted for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            act.ready <= 1'b0;
        end else begin
            act.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            rx.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge i_clk);
        while (!rx.ready);
        decode_byte(b);
        if (b < CHAR_END && (b >= CHAR_FIRST ||
                b inside {CMD_CLEAR, CMD_CHAR, CMD_GOTO, CMD_STR, CMD_PACKED})) begin
            words_sent++;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_text_char();
        int sel;
        int d;
        sel = $urandom_range(99);
        if (sel < 45) begin
            d = $urandom_range(21);
            if (d < 10) begin
                return 8'(int'(DIGIT_0) + d);
            end else if (d < 16) begin
                return 8'(int'(LOWER_A) + d - 10);
            end
            return 8'(int'(UPPER_A) + d - 16);
        end else if (sel < 55) begin
            return $urandom_range(1) ? SIGN_PLUS : SIGN_MINUS;
        end
        return 8'($urandom_range(int'(CHAR_END) - 1, int'(CHAR_FIRST)));
    endfunction

    // Now and then an ignored byte is slipped in ahead of a character.
    task automatic send_text(input logic [7:0] b);
        logic [7:0] junk;
        if ($urandom_range(99) < 4) begin
            if ($urandom_range(1)) begin
                junk = 8'($urandom_range(255, int'(CHAR_END)));
            end else begin
                junk = 8'($urandom_range(int'(CHAR_FIRST) - 1));
                if (junk inside {CMD_CLEAR, CMD_CHAR, CMD_GOTO, CMD_STR, CMD_PACKED}) begin
                    junk = 8'h1F;
                end
            end
            send_byte(junk);
        end
        send_byte(b);
    endtask

    task automatic send_put_char_seq();
        send_byte(CMD_CLEAR);
        send_byte(CMD_CHAR);
        repeat (2) send_text(pick_text_char());
    endtask

    task automatic send_cursor_seq(input bit with_goto, input bit with_packed);
        send_byte(CMD_CLEAR);
        if (with_goto) begin
            send_byte(CMD_GOTO);
        end
        if (with_packed) begin
            send_byte(CMD_PACKED);
        end
        repeat (with_goto ? 4 : 2) send_text(pick_text_char());
    endtask

    task automatic send_string_seq(input int len);
        send_byte(CMD_CLEAR);
        send_byte(CMD_STR);
        send_text(8'(int'(DIGIT_0) + len));
        repeat (len) send_text(8'($urandom_range(int'(CHAR_END) - 1, int'(CHAR_FIRST))));
    endtask

    task automatic test_directed_cases();
        logic [7:0] script [$];
        script = '{8'h00, 8'hFF,
                   CMD_CLEAR, CMD_CHAR, "4", "1",
                   CMD_CLEAR, CMD_CHAR, "-", "f",
                   CMD_CLEAR, CMD_GOTO, "3", "1", "+", "B",
                   CMD_CLEAR, CMD_PACKED, "!", "9",
                   CMD_CLEAR, CMD_STR, "3", "x", "Y", "}",
                   CMD_CLEAR, CMD_STR, "0"};
        src_idle_pct = 13;
        sink_idle_pct = 65;
        foreach (script[k]) begin
            send_byte(script[k]);
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        int stop_at;
        int sel;
        int len;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 18) begin
                send_put_char_seq();
            end else if (sel < 30) begin
                send_cursor_seq(1'b1, 1'b0);
            end else if (sel < 42) begin
                send_cursor_seq(1'b0, 1'b1);
            end else if (sel < 48) begin
                send_cursor_seq(1'b1, 1'b1);
            end else if (sel < 78) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
                send_string_seq(len);
            end else if (sel < 90) begin
                case ($urandom_range(4))
                    0: send_byte(CMD_CLEAR);
                    1: send_byte(CMD_CHAR);
                    2: send_byte(CMD_GOTO);
                    3: send_byte(CMD_STR);
                    default: send_byte(CMD_PACKED);
                endcase
                repeat ($urandom_range(3, 1)) send_text(pick_text_char());
            end else begin
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_output_stall_fill();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_request = LONG_HOLD;
        send_string_seq(36);
        repeat (6) send_put_char_seq();
    endtask

    task automatic finish_run();
        rx.valid <= 1'b0;
        while (pending_actions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    endtask

    initial begin
        i_rst_n = 1'b0;
        rx.valid = 1'b0;
        rx.rx_byte = 8'h00;
        act.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_random_traffic(13, 65, 110);
        test_random_traffic(65, 13, 110);
        test_random_traffic(0, 0, 110);
        test_output_stall_fill();
        finish_run();
    end
endmodule
